/* hdl/l4pb_pkg.sv */
`default_nettype none
package l4pb_pkg;

    localparam int WORD_BITS    = 32;
    localparam int WORDS        = 8;
    localparam int MAPS         = 4;
    localparam int BUCKETS      = 256;
    localparam int PORT_W       = 16;
    localparam int PROTO_W      = 8;
    localparam int OP_W         = 2;
    localparam int MAP_W        = $clog2(MAPS);
    localparam int WORD_IDX_W   = $clog2(WORDS);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int BUCKET_SHIFT = $clog2(BUCKETS);
    localparam int BUCKET_W     = PORT_W - BUCKET_SHIFT;
    // live words sit in two memories (source / destination), split by protocol
    localparam int LIVE_AW      = MAP_W - 1 + WORD_IDX_W;
    localparam int SNAP_AW      = MAP_W + WORD_IDX_W;
    localparam int WALK_W       = $clog2(MAPS * WORDS + 1);

    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_ENCODE = 2'd1,
        OP_SYNC   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

endpackage
`default_nettype wire

/* hdl/l4pb_if.sv */
`default_nettype none
interface l4pb_in_if import l4pb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [PROTO_W-1:0]    proto;
    logic [PORT_W-1:0]     src_port;
    logic [PORT_W-1:0]     dst_port;
    logic [MAP_W-1:0]      map_select;

    modport source (output valid, op, proto, src_port, dst_port, map_select, input ready);
    modport sink   (input valid, op, proto, src_port, dst_port, map_select, output ready);
endinterface

interface l4pb_out_if import l4pb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [WORD_BITS-1:0]  word;
    logic [MAP_W-1:0]      map_id;
    logic [WORD_IDX_W-1:0] word_index;
    logic                  changed;
    logic                  last;

    modport source (output valid, word, map_id, word_index, changed, last, input ready);
    modport sink   (input valid, word, map_id, word_index, changed, last, output ready);
endinterface
`default_nettype wire

/* hdl/l4pb_ram.sv */
`default_nettype none
module l4pb_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clr,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // entries never written since reset or clear read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

/* hdl/l4_port_bucket_bitmap_core.sv */
// add: taken in S_IDLE and written back in the next cycle in S_ADD; no new request is taken meanwhile
// encode: walks all 32 words, one read in flight, each read only when the output slot is free
// sync: compares the live and snapshot words of the selected map, then emits its 8 words
//   with one read in flight at a time, or a single no-change item; clear acts as it is taken
// each memory has a single read port with a registered read
// reset: i_rst_n synchronous active low, clears control and the per-entry valid bits
`default_nettype none
module l4_port_bucket_bitmap_core import l4pb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    l4pb_in_if.sink    i_in,
    l4pb_out_if.source o_out
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_ENC   = 6'b000100,
        S_SCMP  = 6'b001000,
        S_SEMIT = 6'b010000,
        S_SNONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // add write-back context
    logic [LIVE_AW-1:0]    r_add_src_addr, n_add_src_addr;
    logic [LIVE_AW-1:0]    r_add_dst_addr, n_add_dst_addr;
    logic [BIT_W-1:0]      r_add_src_bit, n_add_src_bit;
    logic [BIT_W-1:0]      r_add_dst_bit, n_add_dst_bit;

    // word walk for encode and sync
    logic [WALK_W-1:0]     r_cnt, n_cnt;
    logic [MAP_W-1:0]      r_sel, n_sel;
    logic                  r_diff, n_diff;
    logic                  r_rd_pend, n_rd_pend;
    logic [MAP_W-1:0]      r_rd_map, n_rd_map;
    logic [WORD_IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic                  r_rd_last, n_rd_last;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [WORD_BITS-1:0]  r_out_word, n_out_word;
    logic [MAP_W-1:0]      r_out_map, n_out_map;
    logic [WORD_IDX_W-1:0] r_out_idx, n_out_idx;
    logic                  r_out_changed, n_out_changed;
    logic                  r_out_last, n_out_last;

    // memory ports
    logic                  clr;
    logic                  src_rd_en, dst_rd_en, snap_rd_en;
    logic [LIVE_AW-1:0]    src_rd_addr, dst_rd_addr;
    logic [SNAP_AW-1:0]    snap_rd_addr;
    logic [WORD_BITS-1:0]  src_rd_data, dst_rd_data, snap_rd_data;
    logic                  src_wr_en, dst_wr_en, snap_wr_en;
    logic [LIVE_AW-1:0]    src_wr_addr, dst_wr_addr;
    logic [SNAP_AW-1:0]    snap_wr_addr;
    logic [WORD_BITS-1:0]  src_wr_data, dst_wr_data, snap_wr_data;

    logic                  in_fire;
    logic                  in_tcp, in_udp;
    logic [BUCKET_W-1:0]   src_bucket, dst_bucket;
    logic                  out_free;
    logic                  walk_issue;
    logic                  walk_done;
    logic                  walk_last;
    logic [MAP_W-1:0]      walk_map;
    logic [WORD_IDX_W-1:0] walk_word;
    logic [WORD_BITS-1:0]  live_rd;
    logic                  word_differs;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_tcp     = (i_in.proto == PROTO_TCP);
    assign in_udp     = (i_in.proto == PROTO_UDP);
    assign src_bucket = i_in.src_port[PORT_W-1:BUCKET_SHIFT];
    assign dst_bucket = i_in.dst_port[PORT_W-1:BUCKET_SHIFT];

    // output slot is free now or drains at this edge
    assign out_free = !r_out_valid || o_out.ready;

    // encode walks {map, word}; sync walks the words of the selected map
    assign walk_map  = (r_state == S_ENC) ? r_cnt[SNAP_AW-1:WORD_IDX_W] : r_sel;
    assign walk_word = r_cnt[WORD_IDX_W-1:0];
    assign walk_done = (r_state == S_ENC) ? (r_cnt == WALK_W'(MAPS * WORDS))
                                          : (r_cnt == WALK_W'(WORDS));
    assign walk_last = (r_state == S_ENC) ? (r_cnt == WALK_W'(MAPS * WORDS - 1))
                                          : (r_cnt == WALK_W'(WORDS - 1));

    always_comb begin
        walk_issue = 1'b0;
        if (r_state == S_SCMP) begin
            walk_issue = !walk_done;
        end else if (r_state == S_ENC || r_state == S_SEMIT) begin
            // one read in flight, and only when its word has a place to land
            walk_issue = !walk_done && !r_rd_pend && out_free;
        end
    end

    // low map bit picks source or destination memory
    assign live_rd      = r_rd_map[0] ? dst_rd_data : src_rd_data;
    assign word_differs = (live_rd != snap_rd_data);

    always_comb begin
        n_state        = r_state;
        n_add_src_addr = r_add_src_addr;
        n_add_dst_addr = r_add_dst_addr;
        n_add_src_bit  = r_add_src_bit;
        n_add_dst_bit  = r_add_dst_bit;
        n_cnt          = r_cnt;
        n_sel          = r_sel;
        n_diff         = r_diff;
        n_rd_pend      = 1'b0;
        n_rd_map       = r_rd_map;
        n_rd_idx       = r_rd_idx;
        n_rd_last      = r_rd_last;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_word     = r_out_word;
        n_out_map      = r_out_map;
        n_out_idx      = r_out_idx;
        n_out_changed  = r_out_changed;
        n_out_last     = r_out_last;

        clr          = 1'b0;
        src_rd_en    = walk_issue;
        dst_rd_en    = walk_issue;
        src_rd_addr  = {walk_map[MAP_W-1], walk_word};
        dst_rd_addr  = {walk_map[MAP_W-1], walk_word};
        snap_rd_en   = walk_issue && (r_state == S_SCMP);
        snap_rd_addr = {walk_map, walk_word};
        src_wr_en    = 1'b0;
        dst_wr_en    = 1'b0;
        src_wr_addr  = r_add_src_addr;
        dst_wr_addr  = r_add_dst_addr;
        src_wr_data  = src_rd_data | (WORD_BITS'(1) << r_add_src_bit);
        dst_wr_data  = dst_rd_data | (WORD_BITS'(1) << r_add_dst_bit);
        snap_wr_en   = 1'b0;
        snap_wr_addr = {r_rd_map, r_rd_idx};
        snap_wr_data = live_rd;

        // tag of the read issued this cycle
        if (walk_issue) begin
            n_rd_pend = 1'b1;
            n_rd_map  = walk_map;
            n_rd_idx  = walk_word;
            n_rd_last = walk_last;
            n_cnt     = r_cnt + WALK_W'(1);
        end

        unique case (r_state) inside
            S_IDLE: begin
                // read both live words the add will touch
                src_rd_addr = {in_udp, src_bucket[BIT_W +: WORD_IDX_W]};
                dst_rd_addr = {in_udp, dst_bucket[BIT_W +: WORD_IDX_W]};
                src_rd_en   = 1'b0;
                dst_rd_en   = 1'b0;
                if (in_fire) begin
                    unique case (i_in.op)
                        OP_ADD: begin
                            if (in_tcp || in_udp) begin
                                src_rd_en      = 1'b1;
                                dst_rd_en      = 1'b1;
                                n_add_src_addr = {in_udp, src_bucket[BIT_W +: WORD_IDX_W]};
                                n_add_dst_addr = {in_udp, dst_bucket[BIT_W +: WORD_IDX_W]};
                                n_add_src_bit  = src_bucket[BIT_W-1:0];
                                n_add_dst_bit  = dst_bucket[BIT_W-1:0];
                                n_state        = S_ADD;
                            end
                        end
                        OP_ENCODE: begin
                            n_cnt   = '0;
                            n_state = S_ENC;
                        end
                        OP_SYNC: begin
                            n_cnt   = '0;
                            n_sel   = i_in.map_select;
                            n_diff  = 1'b0;
                            n_state = S_SCMP;
                        end
                        OP_CLEAR: begin
                            clr = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                // set the bucket bit in both words read last cycle
                src_wr_en = 1'b1;
                dst_wr_en = 1'b1;
                n_state   = S_IDLE;
            end
            S_ENC, S_SEMIT: begin
                if (r_rd_pend) begin
                    n_out_valid   = 1'b1;
                    n_out_word    = live_rd;
                    n_out_map     = r_rd_map;
                    n_out_idx     = r_rd_idx;
                    n_out_changed = 1'b1;
                    n_out_last    = r_rd_last;
                    if (r_rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCMP: begin
                // copy differing live words into the snapshot
                if (r_rd_pend) begin
                    if (word_differs) begin
                        snap_wr_en = 1'b1;
                        n_diff     = 1'b1;
                    end
                    if (r_rd_last) begin
                        n_cnt   = '0;
                        n_state = (r_diff || word_differs) ? S_SEMIT : S_SNONE;
                    end
                end
            end
            S_SNONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_word    = '0;
                    n_out_map     = r_sel;
                    n_out_idx     = '0;
                    n_out_changed = 1'b0;
                    n_out_last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_diff      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_diff      <= n_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_add_src_addr <= n_add_src_addr;
        r_add_dst_addr <= n_add_dst_addr;
        r_add_src_bit  <= n_add_src_bit;
        r_add_dst_bit  <= n_add_dst_bit;
        r_sel          <= n_sel;
        r_rd_map       <= n_rd_map;
        r_rd_idx       <= n_rd_idx;
        r_rd_last      <= n_rd_last;
        r_out_word     <= n_out_word;
        r_out_map      <= n_out_map;
        r_out_idx      <= n_out_idx;
        r_out_changed  <= n_out_changed;
        r_out_last     <= n_out_last;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.word       = r_out_word;
    assign o_out.map_id     = r_out_map;
    assign o_out.word_index = r_out_idx;
    assign o_out.changed    = r_out_changed;
    assign o_out.last       = r_out_last;

    // source-port bitmaps of tcp and udp
    l4pb_ram #(
        .ADDR_W (LIVE_AW),
        .DATA_W (WORD_BITS)
    ) u_src_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (clr),
        .i_wr_en   (src_wr_en),
        .i_wr_addr (src_wr_addr),
        .i_wr_data (src_wr_data),
        .i_rd_en   (src_rd_en),
        .i_rd_addr (src_rd_addr),
        .o_rd_data (src_rd_data)
    );

    // destination-port bitmaps of tcp and udp
    l4pb_ram #(
        .ADDR_W (LIVE_AW),
        .DATA_W (WORD_BITS)
    ) u_dst_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (clr),
        .i_wr_en   (dst_wr_en),
        .i_wr_addr (dst_wr_addr),
        .i_wr_data (dst_wr_data),
        .i_rd_en   (dst_rd_en),
        .i_rd_addr (dst_rd_addr),
        .o_rd_data (dst_rd_data)
    );

    // snapshots of all four bitmaps
    l4pb_ram #(
        .ADDR_W (SNAP_AW),
        .DATA_W (WORD_BITS)
    ) u_snap_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (clr),
        .i_wr_en   (snap_wr_en),
        .i_wr_addr (snap_wr_addr),
        .i_wr_data (snap_wr_data),
        .i_rd_en   (snap_rd_en),
        .i_rd_addr (snap_rd_addr),
        .o_rd_data (snap_rd_data)
    );

endmodule
`default_nettype wire

/* dv/tb_l4_port_bucket_bitmap_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_l4_port_bucket_bitmap_core;
    import l4pb_pkg::*;

    typedef struct packed {
        t_op                 op;
        logic [PROTO_W-1:0]  proto;
        logic [PORT_W-1:0]   src_port;
        logic [PORT_W-1:0]   dst_port;
        logic [MAP_W-1:0]    map_select;
    } t_port_op;

    typedef struct packed {
        logic [WORD_BITS-1:0]  word;
        logic [MAP_W-1:0]      map_id;
        logic [WORD_IDX_W-1:0] word_index;
        logic                  changed;
        logic                  last;
    } t_bitmap_word;

    // map numbering: tcp src, tcp dst, udp src, udp dst
    localparam logic [MAP_W-1:0] MAP_TCP_SRC = 2'd0;
    localparam logic [MAP_W-1:0] MAP_TCP_DST = 2'd1;
    localparam logic [MAP_W-1:0] MAP_UDP_SRC = 2'd2;
    localparam logic [MAP_W-1:0] MAP_UDP_DST = 2'd3;

    localparam int RANDOM_OPS  = 220;
    localparam int DRAIN_WAIT  = 80;

    logic i_clk;
    logic i_rst_n;

    l4pb_in_if  in_if();
    l4pb_out_if out_if();

    l4_port_bucket_bitmap_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow of the live bitmaps and their snapshots
    logic [WORD_BITS-1:0] live_map [MAPS][WORDS];
    logic [WORD_BITS-1:0] snap_map [MAPS][WORDS];

    t_port_op     port_ops [$];   // items waiting to be driven
    t_bitmap_word due_words [$];  // words the block still owes us

    int unsigned cyc;
    int unsigned mismatches;

    // --------------------------------------------------------------------
    // clock, reset, known input values from time zero
    // --------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.op          = OP_ADD;
        in_if.proto       = '0;
        in_if.src_port    = '0;
        in_if.dst_port    = '0;
        in_if.map_select  = '0;
        out_if.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("tb_l4_port_bucket_bitmap_core: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // idle with odds of 22 in a hundred, except in one window that never idles
    function automatic bit take_break();
        if (cyc >= 400 && cyc < 1200)
            return 1'b0;
        return $urandom_range(0, 99) < 22;
    endfunction

    // --------------------------------------------------------------------
    // predictor
    // --------------------------------------------------------------------
    function automatic void mark_bucket(logic [MAP_W-1:0] map, logic [PORT_W-1:0] port);
        int unsigned bucket;
        bucket = port / BUCKETS;
        // buckets past the end of the bitmap are dropped
        if (bucket >= WORDS * WORD_BITS)
            return;
        live_map[map][bucket / WORD_BITS][bucket % WORD_BITS] = 1'b1;
    endfunction

    function automatic void clear_maps();
        for (int m = 0; m < MAPS; m++) begin
            for (int w = 0; w < WORDS; w++) begin
                live_map[m][w] = '0;
                snap_map[m][w] = '0;
            end
        end
    endfunction

    function automatic void apply_port_op(t_port_op it);
        bit diff;
        t_bitmap_word bw;
        case (it.op)
            OP_ADD: begin
                // only tcp and udp touch the bitmaps
                if (it.proto == PROTO_TCP) begin
                    mark_bucket(MAP_TCP_SRC, it.src_port);
                    mark_bucket(MAP_TCP_DST, it.dst_port);
                end else if (it.proto == PROTO_UDP) begin
                    mark_bucket(MAP_UDP_SRC, it.src_port);
                    mark_bucket(MAP_UDP_DST, it.dst_port);
                end
            end
            OP_ENCODE: begin
                for (int m = 0; m < MAPS; m++) begin
                    for (int w = 0; w < WORDS; w++) begin
                        bw.word       = live_map[m][w];
                        bw.map_id     = m[MAP_W-1:0];
                        bw.word_index = w[WORD_IDX_W-1:0];
                        bw.changed    = 1'b1;
                        bw.last       = (m == MAPS - 1) && (w == WORDS - 1);
                        due_words.insert(due_words.size(), bw);
                    end
                end
            end
            OP_SYNC: begin
                diff = 1'b0;
                for (int w = 0; w < WORDS; w++) begin
                    if (live_map[it.map_select][w] != snap_map[it.map_select][w]) begin
                        snap_map[it.map_select][w] = live_map[it.map_select][w];
                        diff = 1'b1;
                    end
                end
                if (!diff) begin
                    // nothing moved: a single marker word
                    bw.word       = '0;
                    bw.map_id     = it.map_select;
                    bw.word_index = '0;
                    bw.changed    = 1'b0;
                    bw.last       = 1'b1;
                    due_words.insert(due_words.size(), bw);
                end else begin
                    for (int w = 0; w < WORDS; w++) begin
                        bw.word       = snap_map[it.map_select][w];
                        bw.map_id     = it.map_select;
                        bw.word_index = w[WORD_IDX_W-1:0];
                        bw.changed    = 1'b1;
                        bw.last       = (w == WORDS - 1);
                        due_words.insert(due_words.size(), bw);
                    end
                end
            end
            OP_CLEAR: begin
                clear_maps();
            end
            default: ;
        endcase
    endfunction

    // --------------------------------------------------------------------
    // driver: pops the next item once the previous transfer is done
    // --------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (port_ops.size() != 0 && !take_break()) begin
                t_port_op nxt;
                nxt = port_ops.pop_front();
                in_if.valid      <= 1'b1;
                in_if.op         <= nxt.op;
                in_if.proto      <= nxt.proto;
                in_if.src_port   <= nxt.src_port;
                in_if.dst_port   <= nxt.dst_port;
                in_if.map_select <= nxt.map_select;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= !take_break();
    end

    // --------------------------------------------------------------------
    // monitor: check result transfers, then predict from input transfers
    // --------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                t_bitmap_word got;
                t_bitmap_word want;
                got.word       = out_if.word;
                got.map_id     = out_if.map_id;
                got.word_index = out_if.word_index;
                got.changed    = out_if.changed;
                got.last       = out_if.last;
                if (due_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h map %0d idx %0d chg %b last %b",
                                 got.word, got.map_id, got.word_index, got.changed, got.last);
                end else begin
                    want = due_words.pop_front();
                    if (got.word !== want.word || got.map_id !== want.map_id ||
                        got.word_index !== want.word_index ||
                        got.changed !== want.changed || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp word %h map %0d idx %0d chg %b last %b",
                                      " / got word %h map %0d idx %0d chg %b last %b"},
                                     want.word, want.map_id, want.word_index,
                                     want.changed, want.last,
                                     got.word, got.map_id, got.word_index,
                                     got.changed, got.last);
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                t_port_op took;
                took.op         = t_op'(in_if.op);
                took.proto      = in_if.proto;
                took.src_port   = in_if.src_port;
                took.dst_port   = in_if.dst_port;
                took.map_select = in_if.map_select;
                apply_port_op(took);
            end
        end
    end

    // --------------------------------------------------------------------
    // stimulus
    // --------------------------------------------------------------------
    function automatic void queue_op(t_op op, logic [PROTO_W-1:0] proto,
                                     logic [PORT_W-1:0] sp, logic [PORT_W-1:0] dp,
                                     logic [MAP_W-1:0] sel);
        t_port_op it;
        it.op         = op;
        it.proto      = proto;
        it.src_port   = sp;
        it.dst_port   = dp;
        it.map_select = sel;
        port_ops.insert(port_ops.size(), it);
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        case ($urandom_range(0, 19))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h00FF;
            3:       return 16'h0100;
            default: return PORT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        logic [PROTO_W-1:0] pr;
        int unsigned        pick;

        clear_maps();
        cyc        = 0;
        mismatches = 0;

        // directed: port extremes, ignored protocols, every op, sync with
        // and without a change, sync right after a clear
        queue_op(OP_ADD,    PROTO_TCP, 16'h0000, 16'hFFFF, 2'd3);
        queue_op(OP_ADD,    PROTO_UDP, 16'hFFFF, 16'h0000, 2'd0);
        queue_op(OP_ADD,    8'd0,      16'h1234, 16'h5678, 2'd1);
        queue_op(OP_ADD,    8'hFF,     16'hFFFF, 16'hFFFF, 2'd2);
        queue_op(OP_ADD,    8'd16,     16'h4000, 16'h4000, 2'd0);
        queue_op(OP_ADD,    8'd7,      16'h2000, 16'h2000, 2'd0);
        queue_op(OP_ADD,    PROTO_TCP, 16'h00FF, 16'h0100, 2'd0);
        queue_op(OP_ADD,    PROTO_UDP, 16'h8000, 16'h7FFF, 2'd1);
        queue_op(OP_ENCODE, 8'hFF,     16'hFFFF, 16'hFFFF, 2'd3);
        queue_op(OP_SYNC,   PROTO_TCP, 16'h0000, 16'h0000, MAP_TCP_SRC);
        queue_op(OP_SYNC,   PROTO_TCP, 16'h0000, 16'h0000, MAP_TCP_DST);
        queue_op(OP_SYNC,   PROTO_UDP, 16'h0000, 16'h0000, MAP_UDP_SRC);
        queue_op(OP_SYNC,   PROTO_UDP, 16'h0000, 16'h0000, MAP_UDP_DST);
        queue_op(OP_SYNC,   8'd0,      16'h0000, 16'h0000, MAP_TCP_SRC);
        // bucket already set: live unchanged, sync reports no change
        queue_op(OP_ADD,    PROTO_TCP, 16'h0001, 16'hFF00, 2'd2);
        queue_op(OP_SYNC,   8'd0,      16'hFFFF, 16'hFFFF, MAP_TCP_SRC);
        queue_op(OP_ADD,    PROTO_TCP, 16'h5A5A, 16'hA5A5, 2'd1);
        queue_op(OP_SYNC,   8'd0,      16'h0000, 16'h0000, MAP_TCP_DST);
        queue_op(OP_CLEAR,  8'hFF,     16'hFFFF, 16'hFFFF, 2'd3);
        queue_op(OP_SYNC,   8'd0,      16'h0000, 16'h0000, MAP_UDP_SRC);
        queue_op(OP_ENCODE, 8'd0,      16'h0000, 16'h0000, 2'd0);
        queue_op(OP_ADD,    PROTO_UDP, 16'h1F00, 16'hE0FF, 2'd3);
        queue_op(OP_SYNC,   8'd0,      16'h0000, 16'h0000, MAP_UDP_DST);

        // random: mostly tcp/udp adds, with encodes, syncs and the odd clear
        for (int n = 0; n < RANDOM_OPS; n++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 99) % 20) inside
                0, 1, 2: pr = PROTO_W'($urandom_range(0, 255));
                default: pr = ($urandom_range(0, 1) != 0) ? PROTO_TCP : PROTO_UDP;
            endcase
            if (pick < 68)
                queue_op(OP_ADD, pr, pick_port(), pick_port(),
                         MAP_W'($urandom_range(0, 3)));
            else if (pick < 74)
                queue_op(OP_ENCODE, pr, pick_port(), pick_port(),
                         MAP_W'($urandom_range(0, 3)));
            else if (pick < 95)
                queue_op(OP_SYNC, pr, pick_port(), pick_port(),
                         MAP_W'($urandom_range(0, 3)));
            else
                queue_op(OP_CLEAR, pr, pick_port(), pick_port(),
                         MAP_W'($urandom_range(0, 3)));
        end

        @(posedge i_clk);
        while (!i_rst_n || port_ops.size() != 0 || in_if.valid || due_words.size() != 0)
            @(posedge i_clk);
        // let any stray words show up
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && due_words.size() == 0)
            $display("tb_l4_port_bucket_bitmap_core: clean");
        else
            $display("tb_l4_port_bucket_bitmap_core: errors");
        $finish;
    end

endmodule
`default_nettype wire
